// File: hw/rtl/bis_pkg.sv
// Package for the brake intent supervisor: beat types, mode, event and
// item-kind codes, LED bit masks, and the watchdog reset value.
// No dependencies.
`default_nettype none

package bis_pkg;

  localparam logic [2:0] MODE_STARTUP   = 3'd0;
  localparam logic [2:0] MODE_IDLE      = 3'd1;
  localparam logic [2:0] MODE_PENDING   = 3'd2;
  localparam logic [2:0] MODE_CONFIRMED = 3'd3;
  localparam logic [2:0] MODE_RECOVERY  = 3'd4;
  localparam logic [2:0] MODE_SOFT      = 3'd5;
  localparam logic [2:0] MODE_HARD      = 3'd6;

  localparam logic [1:0] KIND_EVENT = 2'd0;
  localparam logic [1:0] KIND_TICK  = 2'd1;
  localparam logic [1:0] KIND_FORCE = 2'd2;

  localparam logic [3:0] EV_VALID_DATA   = 4'd0;
  localparam logic [3:0] EV_ABOVE_THRESH = 4'd1;
  localparam logic [3:0] EV_SUSTAINED    = 4'd2;
  localparam logic [3:0] EV_DROP         = 4'd3;
  localparam logic [3:0] EV_LOW          = 4'd4;
  localparam logic [3:0] EV_REC_COMPLETE = 4'd5;
  localparam logic [3:0] EV_RISE         = 4'd6;
  localparam logic [3:0] EV_MISSING      = 4'd7;
  localparam logic [3:0] EV_INVALID      = 4'd8;
  localparam logic [3:0] EV_SENSOR_FAULT = 4'd9;
  localparam logic [3:0] EV_STABLE       = 4'd10;
  localparam logic [3:0] EV_WD_TIMEOUT   = 4'd11;
  localparam logic [3:0] EV_MANUAL_RESET = 4'd12;

  localparam logic [3:0] LED_GREEN  = 4'b0001;
  localparam logic [3:0] LED_ORANGE = 4'b0010;
  localparam logic [3:0] LED_RED    = 4'b0100;
  localparam logic [3:0] LED_BLUE   = 4'b1000;

  localparam logic [15:0] WATCHDOG_RESET_MS = 16'd10000;
  localparam logic [15:0] ELAPSED_MAX       = 16'hFFFF;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] event_code;
  } in_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       entered;
    logic       brake_cmd_valid;
    logic       brake_on;
    logic [3:0] leds;
  } out_t;

  // Supervisor state carried between the top level and the next-state logic.
  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] elapsed;
    logic [3:0]  leds;
  } sup_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/bis_next.sv
// Next-state logic of the brake intent supervisor: transition table,
// soft-fault watchdog check and entry actions. Depends on bis_pkg.
`default_nettype none

module bis_next (
  input  bis_pkg::sup_state_t cur,
  input  logic [15:0]         limit,
  input  bis_pkg::in_t        item,
  output bis_pkg::sup_state_t nxt,
  output bis_pkg::out_t       result
);
  import bis_pkg::*;

  logic       hit;
  logic [2:0] target;
  logic       fault;

  // Pick the target state, if any.
  always_comb begin
    hit    = 1'b0;
    target = MODE_STARTUP;
    fault  = (item.event_code == EV_MISSING) || (item.event_code == EV_INVALID);
    unique case (item.kind)
      KIND_EVENT: begin
        if (cur.mode == MODE_SOFT && cur.elapsed >= limit) begin
          hit    = 1'b1;
          target = MODE_STARTUP;
        end else begin
          case (cur.mode)
            MODE_STARTUP: begin
              if (item.event_code == EV_VALID_DATA) begin
                hit = 1'b1; target = MODE_IDLE;
              end else if (item.event_code == EV_MISSING) begin
                hit = 1'b1; target = MODE_SOFT;
              end
            end
            MODE_IDLE: begin
              if (item.event_code == EV_ABOVE_THRESH) begin
                hit = 1'b1; target = MODE_PENDING;
              end else if (fault) begin
                hit = 1'b1; target = MODE_SOFT;
              end else if (item.event_code == EV_SENSOR_FAULT) begin
                hit = 1'b1; target = MODE_HARD;
              end
            end
            MODE_PENDING: begin
              if (item.event_code == EV_SUSTAINED) begin
                hit = 1'b1; target = MODE_CONFIRMED;
              end else if (item.event_code == EV_DROP) begin
                hit = 1'b1; target = MODE_IDLE;
              end else if (fault) begin
                hit = 1'b1; target = MODE_SOFT;
              end else if (item.event_code == EV_SENSOR_FAULT) begin
                hit = 1'b1; target = MODE_HARD;
              end
            end
            MODE_CONFIRMED: begin
              if (item.event_code == EV_LOW) begin
                hit = 1'b1; target = MODE_RECOVERY;
              end else if (item.event_code == EV_SENSOR_FAULT) begin
                hit = 1'b1; target = MODE_HARD;
              end else if (fault) begin
                hit = 1'b1; target = MODE_SOFT;
              end
            end
            MODE_RECOVERY: begin
              if (item.event_code == EV_REC_COMPLETE) begin
                hit = 1'b1; target = MODE_IDLE;
              end else if (item.event_code == EV_RISE) begin
                hit = 1'b1; target = MODE_PENDING;
              end else if (fault) begin
                hit = 1'b1; target = MODE_SOFT;
              end else if (item.event_code == EV_SENSOR_FAULT) begin
                hit = 1'b1; target = MODE_HARD;
              end
            end
            MODE_SOFT: begin
              if (item.event_code == EV_STABLE) begin
                hit = 1'b1; target = MODE_IDLE;
              end else if (item.event_code == EV_WD_TIMEOUT) begin
                hit = 1'b1; target = MODE_STARTUP;
              end else if (item.event_code == EV_SENSOR_FAULT) begin
                hit = 1'b1; target = MODE_HARD;
              end
            end
            MODE_HARD: begin
              if (item.event_code == EV_MANUAL_RESET) begin
                hit = 1'b1; target = MODE_STARTUP;
              end
            end
            default: ;
          endcase
        end
      end
      KIND_FORCE: begin
        hit    = 1'b1;
        target = MODE_HARD;
      end
      default: ;
    endcase
  end

  // Apply the tick counter and the entry action.
  always_comb begin
    nxt    = cur;
    result = '0;
    if (item.kind == KIND_TICK && cur.elapsed != ELAPSED_MAX) begin
      nxt.elapsed = cur.elapsed + 16'd1;
    end
    if (hit) begin
      nxt.mode               = target;
      result.entered         = 1'b1;
      result.brake_cmd_valid = 1'b1;
      unique case (target)
        MODE_STARTUP:   nxt.leds = '0;
        MODE_IDLE:      nxt.leds = LED_GREEN;
        MODE_PENDING: begin
          result.brake_cmd_valid = 1'b0;
          nxt.leds               = cur.leds | LED_GREEN | LED_BLUE;
        end
        MODE_CONFIRMED: begin
          result.brake_on = 1'b1;
          nxt.leds        = cur.leds | LED_RED;
        end
        MODE_RECOVERY:  nxt.leds = (cur.leds & ~LED_RED) | LED_BLUE;
        MODE_SOFT: begin
          nxt.elapsed = '0;
          nxt.leds    = (cur.leds | LED_ORANGE) & ~(LED_GREEN | LED_RED);
        end
        MODE_HARD:      nxt.leds = cur.leds | LED_ORANGE | LED_RED;
        default:        nxt.leds = cur.leds;
      endcase
    end
    result.mode = nxt.mode;
    result.leds = nxt.leds;
  end

endmodule

`default_nettype wire

// File: hw/rtl/brake_intent_supervisor_fsm.sv
// Brake intent supervisor: the result of an accepted input beat is in the output
// register in the cycle after it; throughput is one beat per cycle while the output
// does not stall, set by the single pass through the next-state logic into the
// state registers. Synchronous active-high reset returns to startup-safe with the
// counter and LEDs cleared, the watchdog limit at 10000 ms, and no result pending.
// Depends on bis_pkg and bis_next.
`default_nettype none

module brake_intent_supervisor_fsm (
  input  logic          clk,
  input  logic          rst,
  // Watchdog limit register write
  input  logic          cfg_we,
  input  logic [15:0]   cfg_wdata,
  // Input beats
  input  logic          in_valid,
  output logic          in_ready,
  input  bis_pkg::in_t  in_data,
  // Result beats
  output logic          out_valid,
  input  logic          out_ready,
  output bis_pkg::out_t out_data
);
  import bis_pkg::*;

  logic [2:0]  mode;
  logic [15:0] elapsed;
  logic [3:0]  leds;
  logic [15:0] limit;

  sup_state_t cur;
  sup_state_t nxt;
  out_t       result;
  logic       accept;

  // Take a new beat whenever the output register is empty or drains this cycle.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign cur = '{mode: mode, elapsed: elapsed, leds: leds};

  bis_next u_next (
    .cur    (cur),
    .limit  (limit),
    .item   (in_data),
    .nxt    (nxt),
    .result (result)
  );

  // Watchdog limit: written directly, no handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= WATCHDOG_RESET_MS;
    end else if (cfg_we) begin
      limit <= cfg_wdata;
    end
  end

  // Advance supervisor state on each accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_STARTUP;
      elapsed <= '0;
      leds    <= '0;
    end else if (accept) begin
      mode    <= nxt.mode;
      elapsed <= nxt.elapsed;
      leds    <= nxt.leds;
    end
  end

  // Output register: load on accept, hold while stalled, drop when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

  // The reported mode tracks the state register after each accepted beat.
  a_mode_tracks: assert property (@(posedge clk) disable iff (rst)
    accept |=> (out_data.mode == mode))
    else $error("reported mode differs from state register");

  // Brake is never asserted without a command.
  a_brake_cmd: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_data.brake_on || out_data.brake_cmd_valid))
    else $error("brake_on without brake_cmd_valid");

  // Entering soft fault clears the millisecond counter.
  a_soft_clear: assert property (@(posedge clk) disable iff (rst)
    accept ##1 (out_data.entered && out_data.mode == MODE_SOFT) |-> (elapsed == 16'd0))
    else $error("soft fault entry did not clear counter");

  // Mode stays within the seven defined states.
  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    mode <= MODE_HARD)
    else $error("mode outside defined states");

endmodule

`default_nettype wire

// File: bench/brake_intent_supervisor_fsm_tb.sv
// Testbench for brake_intent_supervisor_fsm: directed walks through the mode table,
// watchdog and counter checks, then random traffic under several idle/stall mixes.
// Depends on bis_pkg and the brake_intent_supervisor_fsm RTL.
`timescale 1ns / 100ps

module brake_intent_supervisor_fsm_tb;
  import bis_pkg::*;

  // Marks "no transition" in the local copy of the mode table.
  localparam logic [2:0] NO_MOVE = 3'd7;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_we = 1'b0;
  logic [15:0]   cfg_wdata = '0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  in_t           in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  out_t          out_data;

  // Percent of cycles in which the sender idles / the receiver stalls.
  int src_idle_pct = 0;
  int stall_pct = 0;
  int mismatch_count = 0;

  // Local supervisor state, advanced once per accepted input beat.
  logic [2:0]  sup_mode;
  logic [15:0] sup_elapsed;
  logic [3:0]  sup_leds;
  logic [15:0] sup_limit;

  // Status beats the block owes us, oldest first.
  out_t expected_status[$];

  brake_intent_supervisor_fsm u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Supervisor prediction
  // ---------------------------------------------------------------------------

  // Mode reached from m on event ev, or NO_MOVE when the table has no entry.
  function automatic logic [2:0] mode_after_event(logic [2:0] m, logic [3:0] ev);
    logic data_fault;
    data_fault = (ev == EV_MISSING) || (ev == EV_INVALID);
    case (m)
      MODE_STARTUP: begin
        if (ev == EV_VALID_DATA) return MODE_IDLE;
        if (ev == EV_MISSING) return MODE_SOFT;
      end
      MODE_IDLE: begin
        if (ev == EV_ABOVE_THRESH) return MODE_PENDING;
        if (data_fault) return MODE_SOFT;
        if (ev == EV_SENSOR_FAULT) return MODE_HARD;
      end
      MODE_PENDING: begin
        if (ev == EV_SUSTAINED) return MODE_CONFIRMED;
        if (ev == EV_DROP) return MODE_IDLE;
        if (data_fault) return MODE_SOFT;
        if (ev == EV_SENSOR_FAULT) return MODE_HARD;
      end
      MODE_CONFIRMED: begin
        if (ev == EV_LOW) return MODE_RECOVERY;
        if (ev == EV_SENSOR_FAULT) return MODE_HARD;
        if (data_fault) return MODE_SOFT;
      end
      MODE_RECOVERY: begin
        if (ev == EV_REC_COMPLETE) return MODE_IDLE;
        if (ev == EV_RISE) return MODE_PENDING;
        if (data_fault) return MODE_SOFT;
        if (ev == EV_SENSOR_FAULT) return MODE_HARD;
      end
      MODE_SOFT: begin
        if (ev == EV_STABLE) return MODE_IDLE;
        if (ev == EV_WD_TIMEOUT) return MODE_STARTUP;
        if (ev == EV_SENSOR_FAULT) return MODE_HARD;
      end
      MODE_HARD: begin
        if (ev == EV_MANUAL_RESET) return MODE_STARTUP;
      end
      default: ;
    endcase
    return NO_MOVE;
  endfunction

  // Advance the local state by one beat and return the status it produces.
  function automatic out_t supervise_step(in_t beat);
    out_t       status;
    logic [2:0] target;
    status = '0;
    target = NO_MOVE;
    case (beat.kind)
      KIND_EVENT: begin
        // The soft-fault watchdog overrides the table, unknown events included.
        if (sup_mode == MODE_SOFT && sup_elapsed >= sup_limit)
          target = MODE_STARTUP;
        else
          target = mode_after_event(sup_mode, beat.event_code);
      end
      KIND_TICK: begin
        if (sup_elapsed != ELAPSED_MAX) sup_elapsed++;
      end
      KIND_FORCE: target = MODE_HARD;
      default: ;  // unused kind: state holds, status just reports it
    endcase

    // Entry action; runs on re-entry into the same mode as well.
    if (target != NO_MOVE) begin
      sup_mode = target;
      status.entered = 1'b1;
      status.brake_cmd_valid = 1'b1;
      case (target)
        MODE_STARTUP: sup_leds = '0;
        MODE_IDLE: sup_leds = LED_GREEN;
        MODE_PENDING: begin
          status.brake_cmd_valid = 1'b0;
          sup_leds |= LED_GREEN | LED_BLUE;
        end
        MODE_CONFIRMED: begin
          status.brake_on = 1'b1;
          sup_leds |= LED_RED;
        end
        MODE_RECOVERY: sup_leds = (sup_leds & ~LED_RED) | LED_BLUE;
        MODE_SOFT: begin
          sup_elapsed = '0;
          sup_leds = (sup_leds | LED_ORANGE) & ~(LED_GREEN | LED_RED);
        end
        default: sup_leds |= LED_ORANGE | LED_RED;  // hard fault
      endcase
    end
    status.mode = sup_mode;
    status.leds = sup_leds;
    return status;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic in_t beat_of(logic [1:0] kind, logic [3:0] ev);
    in_t beat;
    beat.kind = kind;
    beat.event_code = ev;
    return beat;
  endfunction

  // Pick an event that mostly moves the supervisor out of mode m, favoring
  // the normal intent path so the deeper modes get plenty of visits.
  function automatic logic [3:0] likely_event(logic [2:0] m);
    logic [3:0] data_fault;
    int         roll;
    data_fault = ($urandom_range(1) == 0) ? EV_MISSING : EV_INVALID;
    roll = $urandom_range(9);
    case (m)
      MODE_STARTUP:   return (roll < 6) ? EV_VALID_DATA : EV_MISSING;
      MODE_IDLE:      return (roll < 6) ? EV_ABOVE_THRESH :
                             (roll < 9) ? data_fault : EV_SENSOR_FAULT;
      MODE_PENDING:   return (roll < 4) ? EV_SUSTAINED : (roll < 6) ? EV_DROP :
                             (roll < 9) ? data_fault : EV_SENSOR_FAULT;
      MODE_CONFIRMED: return (roll < 6) ? EV_LOW :
                             (roll < 9) ? data_fault : EV_SENSOR_FAULT;
      MODE_RECOVERY:  return (roll < 4) ? EV_REC_COMPLETE : (roll < 7) ? EV_RISE :
                             (roll < 9) ? data_fault : EV_SENSOR_FAULT;
      MODE_SOFT:      return (roll < 5) ? EV_STABLE :
                             (roll < 8) ? EV_WD_TIMEOUT : EV_SENSOR_FAULT;
      default:        return (roll < 8) ? EV_MANUAL_RESET : 4'($urandom_range(12));
    endcase
  endfunction

  // Mostly well-formed events and ticks; a slice of raw noise (unused kind,
  // unknown event codes) and forced faults. Dwell on ticks in soft fault so
  // the watchdog gets reached.
  function automatic in_t random_beat();
    int         roll;
    logic [3:0] any_ev;
    roll = $urandom_range(99);
    any_ev = 4'($urandom_range(15));
    if (roll < 8) return beat_of(2'($urandom_range(3)), any_ev);
    if (roll < 11) return beat_of(KIND_FORCE, any_ev);
    if (roll < ((sup_mode == MODE_SOFT) ? 60 : 28)) return beat_of(KIND_TICK, any_ev);
    return beat_of(KIND_EVENT, likely_event(sup_mode));
  endfunction

  // Send one input beat: idle at random first, then hold valid and payload
  // until the handshake lands, and log the predicted status at that edge.
  task automatic send_beat(input in_t beat);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_status.push_back(supervise_step(beat));
  endtask

  task automatic send_event(input logic [3:0] ev);
    send_beat(beat_of(KIND_EVENT, ev));
  endtask

  // Drop valid and hold off until every owed status beat has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_status.size() != 0);
  endtask

  // Write the watchdog limit only with the block idle; mirror it locally.
  task automatic write_limit(input logic [15:0] ms);
    wait_drained();
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= ms;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sup_limit = ms;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and checker
  // ---------------------------------------------------------------------------

  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want) flag_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
  endtask

  // Every status beat taken at an edge pairs with the oldest prediction.
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_status.size() == 0) begin
        flag_mismatch($sformatf("status beat 0x%0h with nothing expected", out_data));
      end else begin
        want = expected_status.pop_front();
        compare_field("mode", out_data.mode, want.mode);
        compare_field("entered", out_data.entered, want.entered);
        compare_field("brake_cmd_valid", out_data.brake_cmd_valid, want.brake_cmd_valid);
        compare_field("brake_on", out_data.brake_on, want.brake_on);
        compare_field("leds", out_data.leds, want.leds);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Walk every table entry on the intent path and a selection of the fault
  // exits, with the reset watchdog limit still in place.
  task automatic test_mode_table();
    send_beat(beat_of(2'd3, EV_VALID_DATA));     // unused kind straight out of reset
    send_event(4'd13);                           // unknown event
    send_event(EV_ABOVE_THRESH);                 // no entry for it in startup-safe
    send_event(EV_VALID_DATA);                   // -> idle
    send_event(EV_ABOVE_THRESH);                 // -> pending
    send_event(EV_SUSTAINED);                    // -> confirmed, brake on
    send_event(EV_LOW);                          // -> recovery
    send_event(EV_RISE);                         // -> pending
    send_event(EV_DROP);                         // -> idle
    send_event(EV_ABOVE_THRESH);
    send_event(EV_SUSTAINED);
    send_event(EV_LOW);
    send_event(EV_REC_COMPLETE);                 // -> idle
    send_event(EV_MISSING);                      // -> soft fault
    send_beat(beat_of(KIND_TICK, 4'hF));
    send_event(EV_STABLE);                       // -> idle
    send_event(EV_INVALID);                      // -> soft fault
    send_event(EV_WD_TIMEOUT);                   // -> startup-safe
    send_event(EV_MISSING);                      // -> soft fault
    send_event(EV_SENSOR_FAULT);                 // -> hard fault
    send_beat(beat_of(KIND_FORCE, 4'hF));        // re-enter hard fault
    send_event(EV_VALID_DATA);                   // hard fault ignores it
    send_event(EV_MANUAL_RESET);                 // -> startup-safe
    send_beat(beat_of(2'd3, 4'hF));
    send_beat(beat_of(KIND_FORCE, EV_VALID_DATA));
    send_event(EV_MANUAL_RESET);
  endtask

  // Zero limit trips on the first event in soft fault; a limit of one needs one tick,
  // and unknown events are still subject to the watchdog.
  task automatic test_watchdog_limits();
    write_limit(16'd0);
    send_event(EV_MISSING);                      // -> soft fault
    send_event(EV_MANUAL_RESET);                 // watchdog -> startup-safe
    write_limit(16'd1);
    send_event(EV_MISSING);
    send_event(EV_VALID_DATA);                   // counter still below the limit
    send_beat(beat_of(KIND_TICK, EV_STABLE));
    send_event(4'd14);                           // watchdog -> startup-safe
  endtask

  // Count a longer run of ticks against a larger limit, one short and then past it.
  task automatic test_counter_threshold();
    write_limit(16'd60);
    send_event(EV_MISSING);                      // clears the counter
    repeat (59) send_beat(beat_of(KIND_TICK, 4'($urandom_range(15))));
    send_event(EV_VALID_DATA);                   // one short: stays in soft fault
    repeat (3) send_beat(beat_of(KIND_TICK, 4'($urandom_range(15))));
    send_event(4'd13);                           // past the limit -> startup-safe
  endtask

  // Random traffic in phases of different idle/stall mixes and limits.
  task automatic test_random_traffic();
    int idle_pct [4];
    int stall_mix [4];
    logic [15:0] limits [4];
    idle_pct  = '{0, 51, 0, 21};
    stall_mix = '{0, 0, 51, 21};
    limits    = '{16'd3, 16'hFFFF, 16'd0, 16'($urandom_range(12, 1))};
    for (int ph = 0; ph < 4; ph++) begin
      write_limit(limits[ph]);
      src_idle_pct = idle_pct[ph];
      stall_pct    = stall_mix[ph];
      repeat (150) begin
        // Now and then hold off until the output side has fully drained.
        if ($urandom_range(39) == 0) wait_drained();
        send_beat(random_beat());
      end
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Run
  // ---------------------------------------------------------------------------

  initial begin
    sup_mode    = MODE_STARTUP;
    sup_elapsed = '0;
    sup_leds    = '0;
    sup_limit   = WATCHDOG_RESET_MS;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_mode_table();
    test_watchdog_limits();
    test_counter_threshold();
    test_random_traffic();

    // Let a late or stray status beat show up before the verdict.
    src_idle_pct = 0;
    stall_pct = 0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** brake_intent_supervisor_fsm: PASSED **");
    end else begin
      $display("** brake_intent_supervisor_fsm: FAILED **");
    end
    $finish;
  end

  // Hang guard: the full run needs well under a fifth of this.
  initial begin
    #2_000_000;
    $display("** brake_intent_supervisor_fsm: FAILED **");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/bis_pkg.sv
hw/rtl/bis_next.sv
hw/rtl/brake_intent_supervisor_fsm.sv
bench/brake_intent_supervisor_fsm_tb.sv
